// ===== hw/rtl/serial_block_loader_macros.svh =====
// Assertion macros used by the loader RTL (sbl_engine).
// Depends on nothing; include by bare file name where assertions are written.
`ifndef SERIAL_BLOCK_LOADER_MACROS_SVH
`define SERIAL_BLOCK_LOADER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SBL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sbl_pkg.sv =====
// Package for the serial block loader: codes, widths, phase and payload types.
// Depends on nothing; used by the channel interfaces and every loader module.
package sbl_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int BLK_CNT_W   = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int ADDR_W      = 24;
    localparam int OFF_W       = ADDR_W + 1;
    localparam int BYTE_W      = 8;
    localparam int FUNC_W      = 2;
    localparam int CFG_IDX_W   = 1;

    localparam logic [BYTE_W-1:0] RDY_EXT     = 8'h51;
    localparam logic [BYTE_W-1:0] RDY_INT     = 8'h61;
    localparam logic [BYTE_W-1:0] INJ_RDY_EXT = 8'h52;
    localparam logic [BYTE_W-1:0] INJ_RDY_INT = 8'h62;
    localparam logic [BYTE_W-1:0] INJ_ABT_EXT = 8'h53;
    localparam logic [BYTE_W-1:0] INJ_ABT_INT = 8'h63;
    localparam logic [BYTE_W-1:0] ACK_CODE    = 8'h53;
    localparam logic [ADDR_W-1:0] BASE_RESET  = 24'h00a000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE = 1'b1;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_ABORT = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_BYTE  = 2'd0,
        FN_TICK  = 2'd1,
        FN_START = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SHAKE = 3'd1,
        PH_LEN0  = 3'd2,
        PH_LEN1  = 3'd3,
        PH_LEN2  = 3'd4,
        PH_DATA  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic              internal_mode;
        logic [ADDR_W-1:0] internal_base;
    } t_cfg;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              wr_valid;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              done_res;
        logic              status;
    } t_result;

endpackage

// ===== hw/rtl/sbl_channels.sv =====
// Valid/ready channel interfaces for loader input words and result words.
// Depends on sbl_pkg for field widths.
interface sbl_in_if;
    logic                                valid;
    logic                                ready;
    logic [sbl_pkg::FUNC_W-1:0]          func;
    logic [sbl_pkg::BYTE_W-1:0]          rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface sbl_out_if;
    logic                                valid;
    logic                                ready;
    logic                                tx_valid;
    logic [sbl_pkg::BYTE_W-1:0]          tx_byte;
    logic                                wr_valid;
    logic [sbl_pkg::ADDR_W-1:0]          wr_addr;
    logic [sbl_pkg::BYTE_W-1:0]          wr_data;
    logic                                done_res;
    logic                                status;

    modport source (output valid, output tx_valid, output tx_byte, output wr_valid,
                    output wr_addr, output wr_data, output done_res, output status,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input wr_valid,
                    input wr_addr, input wr_data, input done_res, input status,
                    output ready);
endinterface

// ===== hw/rtl/serial_block_loader.sv =====
// Serial block loader: accepts one word per cycle while the result side does not
// stall and returns one result word for each; the rate is set by a single
// phase-machine step between the input register and the result
// register. Start words send the ready code, the handshake and three length
// bytes follow, and data bytes become memory writes at base plus offset with an
// ack after every block; the load ends at the first block boundary at or past
// the length. Configuration writes take effect on the next cycle.
// Depends on sbl_pkg, sbl_channels and sbl_engine.
module serial_block_loader (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sbl_in_if.sink                         i_in,
    sbl_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [sbl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbl_pkg::ADDR_W-1:0]     i_cfg_data
);
    import sbl_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_cfg    r_cfg;
    t_result step_res;
    logic    adv;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.func    <= i_in.func;
            r_in.rx_byte <= i_in.rx_byte;
        end
    end

    sbl_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.internal_mode <= 1'b0;
            r_cfg.internal_base <= BASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_MODE: r_cfg.internal_mode <= i_cfg_data[0];
                CFG_IDX_BASE: r_cfg.internal_base <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.tx_valid = r_out.tx_valid;
    assign o_out.tx_byte  = r_out.tx_byte;
    assign o_out.wr_valid = r_out.wr_valid;
    assign o_out.wr_addr  = r_out.wr_addr;
    assign o_out.wr_data  = r_out.wr_data;
    assign o_out.done_res = r_out.done_res;
    assign o_out.status   = r_out.status;

endmodule

// ===== hw/rtl/sbl_engine.sv =====
// Loader protocol engine: phase machine, length, block counter and offset.
// Depends on sbl_pkg and serial_block_loader_macros.svh.
`include "serial_block_loader_macros.svh"

module sbl_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  sbl_pkg::t_item   i_item,
    input  sbl_pkg::t_cfg    i_cfg,
    output sbl_pkg::t_result o_res
);
    import sbl_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [ADDR_W-1:0]      r_len,   n_len;
    logic [BLK_CNT_W-1:0]   r_cnt,   n_cnt;
    logic [OFF_W-1:0]       r_off,   n_off;

    logic [BYTE_W-1:0]      rdy_code;
    logic [BYTE_W-1:0]      injrdy_code;
    logic [BYTE_W-1:0]      injabt_code;
    logic [ADDR_W-1:0]      base_sel;
    logic [OFF_W-1:0]       off_inc;
    logic                   block_end;
    logic                   load_end;

    assign rdy_code    = i_cfg.internal_mode ? RDY_INT     : RDY_EXT;
    assign injrdy_code = i_cfg.internal_mode ? INJ_RDY_INT : INJ_RDY_EXT;
    assign injabt_code = i_cfg.internal_mode ? INJ_ABT_INT : INJ_ABT_EXT;
    assign base_sel    = i_cfg.internal_mode ? i_cfg.internal_base : '0;
    assign off_inc     = r_off + OFF_W'(1);
    assign block_end   = (r_cnt == BLK_CNT_W'(BLOCK_BYTES - 1));
    assign load_end    = (off_inc >= {1'b0, r_len});

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_off   = r_off;
        if (i_adv) begin
            unique case (i_item.func)
                FN_START: begin
                    n_phase = PH_SHAKE;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_off   = '0;
                end
                FN_BYTE: begin
                    unique case (r_phase)
                        PH_SHAKE: begin
                            if (i_item.rx_byte == injabt_code) begin
                                n_phase = PH_IDLE;
                            end else if (i_item.rx_byte == injrdy_code) begin
                                n_phase = PH_LEN0;
                            end
                        end
                        PH_LEN0: begin
                            n_len   = {i_item.rx_byte, 16'h0000};
                            n_phase = PH_LEN1;
                        end
                        PH_LEN1: begin
                            n_len   = r_len | {8'h00, i_item.rx_byte, 8'h00};
                            n_phase = PH_LEN2;
                        end
                        PH_LEN2: begin
                            n_len   = r_len | {16'h0000, i_item.rx_byte};
                            n_off   = '0;
                            n_cnt   = '0;
                            n_phase = PH_DATA;
                        end
                        PH_DATA: begin
                            n_off = off_inc;
                            if (block_end) begin
                                n_cnt = '0;
                                if (load_end) begin
                                    n_phase = PH_IDLE;
                                end
                            end else begin
                                n_cnt = r_cnt + BLK_CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_res = '0;
        unique case (i_item.func)
            FN_START: begin
                o_res.tx_valid = 1'b1;
                o_res.tx_byte  = rdy_code;
            end
            FN_TICK: begin
                if (r_phase == PH_SHAKE) begin
                    o_res.tx_valid = 1'b1;
                    o_res.tx_byte  = rdy_code;
                end
            end
            FN_BYTE: begin
                unique case (r_phase)
                    PH_SHAKE: begin
                        if (i_item.rx_byte == injabt_code) begin
                            o_res.done_res = 1'b1;
                            o_res.status   = STATUS_ABORT;
                        end else if (i_item.rx_byte == injrdy_code) begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = ACK_CODE;
                        end
                    end
                    PH_LEN2: begin
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = ACK_CODE;
                    end
                    PH_DATA: begin
                        o_res.wr_valid = 1'b1;
                        o_res.wr_addr  = base_sel + r_off[ADDR_W-1:0];
                        o_res.wr_data  = i_item.rx_byte;
                        if (block_end) begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = ACK_CODE;
                            if (load_end) begin
                                o_res.done_res = 1'b1;
                                o_res.status   = STATUS_DONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_cnt   <= '0;
            r_off   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_off   <= n_off;
        end
    end

    `SBL_ASSERT_NXT(a_done_to_idle, i_clk, i_rst_n,
        i_adv && o_res.done_res, r_phase == PH_IDLE,
        "load end did not return to idle")
    `SBL_ASSERT_IMP(a_write_in_data, i_clk, i_rst_n,
        i_adv && o_res.wr_valid, r_phase == PH_DATA,
        "memory write outside data phase")
    `SBL_ASSERT_NXT(a_block_ack_clears, i_clk, i_rst_n,
        i_adv && o_res.wr_valid && o_res.tx_valid, r_cnt == '0,
        "block counter not cleared after block ack")

endmodule

// ===== sim/tb_serial_block_loader.sv =====
`timescale 1ns / 1ps
// Testbench for serial_block_loader: drives load sequences, configuration changes
// and noise through the valid/ready channels and checks every result word.
// Depends on sbl_pkg, sbl_channels and the serial_block_loader RTL.
module tb_serial_block_loader;
    import sbl_pkg::*;

    localparam int ITEMS       = 1100;
    localparam int LIMIT       = 300000;
    localparam int HOLD_CYCLES = 100;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    class load_tracker;
        logic                 mode;
        logic [ADDR_W-1:0]    base;
        t_phase               ph;
        logic [ADDR_W-1:0]    len;
        logic [BLK_CNT_W:0]   cnt;
        logic [OFF_W-1:0]     off;
        t_result              pending_results[$];
        int                   fails;

        function new();
            mode  = 1'b0;
            base  = BASE_RESET;
            ph    = PH_IDLE;
            len   = '0;
            cnt   = '0;
            off   = '0;
            fails = 0;
        endfunction

        function void set_regs(logic m, logic [ADDR_W-1:0] b);
            mode = m;
            base = b;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_word(logic [FUNC_W-1:0] fn, logic [BYTE_W-1:0] rx);
            t_result           r;
            logic [BYTE_W-1:0] rdy;
            logic [BYTE_W-1:0] inj_rdy;
            logic [BYTE_W-1:0] inj_abt;
            r       = '0;
            rdy     = mode ? RDY_INT : RDY_EXT;
            inj_rdy = mode ? INJ_RDY_INT : INJ_RDY_EXT;
            inj_abt = mode ? INJ_ABT_INT : INJ_ABT_EXT;
            case (fn)
                FN_START: begin
                    ph  = PH_SHAKE;
                    len = '0;
                    cnt = '0;
                    off = '0;
                    r.tx_valid = 1'b1;
                    r.tx_byte  = rdy;
                end
                FN_TICK: begin
                    if (ph == PH_SHAKE) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = rdy;
                    end
                end
                FN_BYTE: begin
                    case (ph)
                        PH_SHAKE: begin
                            if (rx == inj_abt) begin
                                ph = PH_IDLE;
                                r.done_res = 1'b1;
                                r.status   = STATUS_ABORT;
                            end else if (rx == inj_rdy) begin
                                ph = PH_LEN0;
                                r.tx_valid = 1'b1;
                                r.tx_byte  = ACK_CODE;
                            end
                        end
                        PH_LEN0: begin
                            len = {rx, 16'h0000};
                            ph  = PH_LEN1;
                        end
                        PH_LEN1: begin
                            len[15:8] = rx;
                            ph = PH_LEN2;
                        end
                        PH_LEN2: begin
                            len[7:0] = rx;
                            off = '0;
                            cnt = '0;
                            ph  = PH_DATA;
                            r.tx_valid = 1'b1;
                            r.tx_byte  = ACK_CODE;
                        end
                        PH_DATA: begin
                            r.wr_valid = 1'b1;
                            r.wr_addr  = (mode ? base : '0) + off[ADDR_W-1:0];
                            r.wr_data  = rx;
                            off = off + 1'b1;
                            cnt = cnt + 1'b1;
                            if (cnt >= BLOCK_BYTES) begin
                                cnt = '0;
                                r.tx_valid = 1'b1;
                                r.tx_byte  = ACK_CODE;
                                if (off >= {1'b0, len}) begin
                                    ph = PH_IDLE;
                                    r.done_res = 1'b1;
                                    r.status   = STATUS_DONE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result word with no word outstanding");
                fails++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("tx_valid", want.tx_valid, got.tx_valid);
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("wr_valid", want.wr_valid, got.wr_valid);
            compare_field("wr_addr", want.wr_addr, got.wr_addr);
            compare_field("wr_data", want.wr_data, got.wr_data);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [ADDR_W-1:0]    cfg_data;
    bit                   src_idle;
    bit                   sink_idle;
    bit                   hold_req;
    int                   words_sent = 0;
    int                   cycle_count = 0;
    load_tracker          board = new();

    sbl_in_if  in_ch ();
    sbl_out_if out_ch ();

    serial_block_loader i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk) begin : monitor
        t_result seen;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                seen.tx_valid = out_ch.tx_valid;
                seen.tx_byte  = out_ch.tx_byte;
                seen.wr_valid = out_ch.wr_valid;
                seen.wr_addr  = out_ch.wr_addr;
                seen.wr_data  = out_ch.wr_data;
                seen.done_res = out_ch.done_res;
                seen.status   = out_ch.status;
                board.check_word(seen);
            end
            if (in_ch.valid && in_ch.ready) begin
                board.note_word(in_ch.func, in_ch.rx_byte);
            end
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = sink_idle ? $urandom_range(0, 5) : 0;
            repeat (stall) begin
                out_ch.ready <= 1'b0;
                @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    task automatic send_word(logic [FUNC_W-1:0] fn, logic [BYTE_W-1:0] rx);
        int gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.func    <= fn;
        in_ch.rx_byte <= rx;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_len(logic [ADDR_W-1:0] l);
        send_word(FN_BYTE, l[23:16]);
        send_word(FN_BYTE, l[15:8]);
        send_word(FN_BYTE, l[7:0]);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic m, logic [ADDR_W-1:0] b);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_MODE;
        cfg_data <= {{(ADDR_W-1){1'b0}}, m};
        @(negedge clk);
        cfg_idx  <= CFG_IDX_BASE;
        cfg_data <= b;
        @(negedge clk);
        cfg_we   <= 1'b0;
        board.set_regs(m, b);
    endtask

    task automatic reconfigure();
        logic [ADDR_W-1:0] b;
        drain_results();
        case ($urandom_range(0, 4))
            0: b = '0;
            1: b = '1;
            2: b = BASE_RESET;
            3: b = 24'hFFFFC0 + ADDR_W'($urandom_range(0, 63));
            default: b = ADDR_W'($urandom);
        endcase
        cfg_write(1'($urandom_range(0, 1)), b);
    endtask

    function automatic logic [BYTE_W-1:0] inj_ready();
        return board.mode ? INJ_RDY_INT : INJ_RDY_EXT;
    endfunction

    function automatic logic [BYTE_W-1:0] junk_byte();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom);
        if (v == inj_ready() || v == (board.mode ? INJ_ABT_INT : INJ_ABT_EXT)) v = 8'h00;
        return v;
    endfunction

    initial begin
        int choice;
        int pick;
        int len_val;
        int nbytes;
        int cut;
        int k;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FN_BYTE;
        in_ch.rx_byte = '0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_IDX_MODE;
        cfg_data      = '0;
        src_idle      = 1'b1;
        sink_idle     = 1'b1;
        hold_req      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        cfg_write(1'b0, '0);
        send_word(FN_BYTE, 8'h00);
        send_word(FN_BYTE, 8'hFF);
        send_word(FN_TICK, 8'h00);
        send_word(FN_UNUSED, 8'h5A);
        send_word(FN_START, 8'h00);
        send_word(FN_TICK, 8'hFF);
        send_word(FN_BYTE, 8'hA5);
        send_word(FN_BYTE, INJ_ABT_INT);
        send_word(FN_BYTE, INJ_ABT_EXT);
        send_word(FN_TICK, 8'h00);
        send_word(FN_START, 8'h00);
        send_word(FN_BYTE, INJ_RDY_EXT);
        send_word(FN_BYTE, 8'hFF);
        send_word(FN_START, 8'h00);
        send_word(FN_BYTE, INJ_RDY_EXT);
        send_len(24'h000000);
        send_word(FN_BYTE, 8'h00);
        send_word(FN_BYTE, 8'hFF);
        send_word(FN_BYTE, 8'h5A);
        send_word(FN_START, 8'h00);
        send_word(FN_BYTE, INJ_RDY_EXT);
        send_len(24'hFFFFFF);

        // switch mode mid-load, wrap the address and back up the result side
        drain_results();
        cfg_write(1'b1, 24'hFFFFF0);
        hold_req = 1'b1;
        src_idle = 1'b0;
        repeat (40) send_word(FN_BYTE, BYTE_W'($urandom));
        src_idle = 1'b1;
        drain_results();

        while (words_sent < ITEMS) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            choice    = $urandom_range(0, 99);
            if (choice < 60) begin
                send_word(FN_START, BYTE_W'($urandom));
                repeat ($urandom_range(0, 2)) send_word(FN_TICK, BYTE_W'($urandom));
                repeat ($urandom_range(0, 2)) send_word(FN_BYTE, junk_byte());
                send_word(FN_BYTE, inj_ready());
                pick = $urandom_range(0, 9);
                if (pick < 7) len_val = $urandom_range(0, 192);
                else if (pick < 9) len_val = BLOCK_BYTES * $urandom_range(0, 3);
                else len_val = $urandom_range(0, 24'hFFFFFF);
                send_len(ADDR_W'(len_val));
                if (pick == 9) nbytes = $urandom_range(2, 100);
                else if (len_val == 0) nbytes = BLOCK_BYTES;
                else nbytes = ((len_val + BLOCK_BYTES - 1) / BLOCK_BYTES) * BLOCK_BYTES;
                cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, nbytes - 1) : -1;
                for (k = 0; k < nbytes; k++) begin
                    if (k == cut) reconfigure();
                    send_word(FN_BYTE, BYTE_W'($urandom));
                end
            end else if (choice < 72) begin
                send_word(FN_START, BYTE_W'($urandom));
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 1) != 0) send_word(FN_TICK, BYTE_W'($urandom));
                    else send_word(FN_BYTE, junk_byte());
                end
                send_word(FN_BYTE, board.mode ? INJ_ABT_INT : INJ_ABT_EXT);
            end else if (choice < 84) begin
                send_word(FN_START, BYTE_W'($urandom));
                if ($urandom_range(0, 3) != 0) begin
                    send_word(FN_BYTE, inj_ready());
                    repeat ($urandom_range(0, 2)) send_word(FN_BYTE, BYTE_W'($urandom));
                end
            end else if (choice < 94) begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(FUNC_W'($urandom_range(0, 3)), BYTE_W'($urandom));
                end
            end else begin
                reconfigure();
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (board.fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sbl_pkg.sv
hw/rtl/sbl_channels.sv
hw/rtl/sbl_engine.sv
hw/rtl/serial_block_loader.sv
sim/tb_serial_block_loader.sv
